>>> hdl/fdttl_pkg.sv
package fdttl_pkg;

   // input opcodes
   localparam logic [1:0] OP_TICK     = 2'd0;
   localparam logic [1:0] OP_CHECK    = 2'd1;
   localparam logic [1:0] OP_REMEMBER = 2'd2;

   // field and state widths
   localparam int OP_W   = 2;
   localparam int BYTE_W = 8;
   localparam int POS_W  = 8;
   localparam int TIME_W = 32;
   localparam int TTL_W  = 16;

   // time-to-live after reset, in milliseconds
   localparam logic [TTL_W-1:0] TTL_RESET = 16'd500;

endpackage

>>> hdl/frame_dedupe_ttl_cache.sv
// result: the seen result of a check frame passes from the second stage register into the result
// register, which holds it until the transaction is taken
// throughput: one transaction per cycle, set by the single stage after the byte memories, unless results stall
// reset: synchronous, active high; clears the ring, time, frame tracking and loads ttl 500
// slot byte memories are not cleared; a slot reads as empty until it has been stored
module frame_dedupe_ttl_cache #(
   parameter int RING_DEPTH = 8,
   parameter int FRAME_MAX  = 128
) (
   input  logic                           clock,
   input  logic                           reset,
   // input transactions
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [fdttl_pkg::OP_W-1:0]     req_opcode,
   input  logic [fdttl_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic                           req_last,
   // result transactions
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_seen,
   // ttl register write
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [fdttl_pkg::TTL_W-1:0]    csr_ttl_ms
);

   localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int ADDR_W = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;
   localparam logic [fdttl_pkg::POS_W-1:0] POS_MAX = fdttl_pkg::POS_W'(FRAME_MAX);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);

   // second stage register contents
   typedef struct packed {
      logic [fdttl_pkg::OP_W-1:0]   op;
      logic [fdttl_pkg::BYTE_W-1:0] data;
      logic                         last;
      logic                         in_range;
      logic [fdttl_pkg::POS_W-1:0]  pos;
      logic [fdttl_pkg::POS_W-1:0]  pos_after;
      logic                         ovf_after;
      logic [SLOT_W-1:0]            slot;
   } stage_type;

   logic [fdttl_pkg::TTL_W-1:0]  ttl_ff, ttl_in;
   logic [fdttl_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic                         ovf_ff, ovf_in;
   logic [SLOT_W-1:0]            wslot_ff, wslot_in;
   logic                         s1_valid_ff, s1_valid_in;
   stage_type                    s1_ff, s1_in;
   logic [fdttl_pkg::BYTE_W-1:0] rd_byte_ff [RING_DEPTH];
   logic [fdttl_pkg::POS_W-1:0]  len_ff [RING_DEPTH];
   logic [fdttl_pkg::POS_W-1:0]  len_in [RING_DEPTH];
   logic [fdttl_pkg::TIME_W-1:0] stamp_ff [RING_DEPTH];
   logic [fdttl_pkg::TIME_W-1:0] stamp_in [RING_DEPTH];
   logic [RING_DEPTH-1:0]        match_ff, match_in, match_next, hit;
   logic [fdttl_pkg::TIME_W-1:0] now_ff, now_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_seen_ff, rsp_seen_in;

   logic accept, s1_hold, s1_fire, s1_result, is_byte, in_range, ovf_after;
   logic mem_wr, mem_rd;
   logic [fdttl_pkg::POS_W-1:0] pos_after;

   // ttl register, always writable
   assign csr_ready = 1'b1;
   assign ttl_in    = (csr_valid && csr_ready) ? csr_ttl_ms : ttl_ff;

   // handshake
   assign s1_result = (s1_ff.op == fdttl_pkg::OP_CHECK) && s1_ff.last;
   assign s1_hold   = s1_valid_ff && s1_result && rsp_valid_ff && rsp_stall;
   assign s1_fire   = s1_valid_ff && !s1_hold;
   assign req_stall = s1_hold;
   assign accept    = req_valid && !req_stall;

   // frame tracking at the input: byte position, overflow and ring write pointer
   assign is_byte  = (req_opcode == fdttl_pkg::OP_CHECK) ||
                     (req_opcode == fdttl_pkg::OP_REMEMBER);
   assign in_range = (pos_ff < POS_MAX);
   assign pos_after = in_range ? pos_ff + fdttl_pkg::POS_W'(1) : pos_ff;
   assign ovf_after = ovf_ff || !in_range;
   assign mem_wr   = accept && (req_opcode == fdttl_pkg::OP_REMEMBER) && in_range;
   assign mem_rd   = accept && (req_opcode == fdttl_pkg::OP_CHECK) && in_range;

   always_comb begin
      pos_in   = pos_ff;
      ovf_in   = ovf_ff;
      wslot_in = wslot_ff;
      if (accept && is_byte) begin
         if (req_last) begin
            pos_in = '0;
            ovf_in = 1'b0;
            if ((req_opcode == fdttl_pkg::OP_REMEMBER) && !ovf_after) begin
               wslot_in = (wslot_ff == SLOT_LAST) ? '0 : wslot_ff + SLOT_W'(1);
            end
         end else begin
            pos_in = pos_after;
            ovf_in = ovf_after;
         end
      end
   end

   // second stage load
   always_comb begin
      s1_in.op        = req_opcode;
      s1_in.data      = req_data_byte;
      s1_in.last      = req_last;
      s1_in.in_range  = in_range;
      s1_in.pos       = pos_ff;
      s1_in.pos_after = pos_after;
      s1_in.ovf_after = ovf_after;
      s1_in.slot      = wslot_ff;
      s1_valid_in     = s1_hold ? 1'b1 : accept;
   end

   // one byte memory per slot, written by remember bytes, read by check bytes
   for (genvar g = 0; g < RING_DEPTH; g++) begin : g_slot
      logic [fdttl_pkg::BYTE_W-1:0] mem_ff [FRAME_MAX];

      always_ff @(posedge clock) begin
         if (mem_wr && (wslot_ff == SLOT_W'(g))) begin
            mem_ff[pos_ff[ADDR_W-1:0]] <= req_data_byte;
         end
         if (mem_rd) begin
            rd_byte_ff[g] <= mem_ff[pos_ff[ADDR_W-1:0]];
         end
      end
   end

   // per-slot byte compare and age check
   always_comb begin
      for (int i = 0; i < RING_DEPTH; i++) begin
         match_next[i] = match_ff[i];
         if ((s1_ff.op == fdttl_pkg::OP_CHECK) && s1_ff.in_range &&
             ((s1_ff.pos >= len_ff[i]) || (rd_byte_ff[i] != s1_ff.data))) begin
            match_next[i] = 1'b0;
         end
         hit[i] = match_next[i] && (len_ff[i] == s1_ff.pos_after) &&
                  ((now_ff - stamp_ff[i]) < {{(fdttl_pkg::TIME_W-fdttl_pkg::TTL_W){1'b0}}, ttl_ff});
      end
   end

   // ring state, time and match vector updated by the second stage
   always_comb begin
      now_in   = now_ff;
      match_in = match_ff;
      len_in   = len_ff;
      stamp_in = stamp_ff;
      if (s1_fire) begin
         unique case (s1_ff.op)
            fdttl_pkg::OP_TICK: begin
               now_in = now_ff + fdttl_pkg::TIME_W'(1);
            end
            fdttl_pkg::OP_CHECK: begin
               match_in = s1_ff.last ? '1 : match_next;
            end
            fdttl_pkg::OP_REMEMBER: begin
               if (s1_ff.in_range) begin
                  len_in[s1_ff.slot] = '0;
               end
               if (s1_ff.last) begin
                  match_in = '1;
                  if (s1_ff.ovf_after) begin
                     len_in[s1_ff.slot] = '0;
                  end else begin
                     len_in[s1_ff.slot]   = s1_ff.pos_after;
                     stamp_in[s1_ff.slot] = now_ff;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_seen_in  = rsp_seen_ff;
      if (s1_fire && s1_result) begin
         rsp_valid_in = 1'b1;
         rsp_seen_in  = !s1_ff.ovf_after && (|hit);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_seen  = rsp_seen_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff       <= fdttl_pkg::TTL_RESET;
         pos_ff       <= '0;
         ovf_ff       <= 1'b0;
         wslot_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         match_ff     <= '1;
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < RING_DEPTH; i++) begin
            len_ff[i]   <= '0;
            stamp_ff[i] <= '0;
         end
      end else begin
         ttl_ff       <= ttl_in;
         pos_ff       <= pos_in;
         ovf_ff       <= ovf_in;
         wslot_ff     <= wslot_in;
         s1_valid_ff  <= s1_valid_in;
         match_ff     <= match_in;
         now_ff       <= now_in;
         rsp_valid_ff <= rsp_valid_in;
         len_ff       <= len_in;
         stamp_ff     <= stamp_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (!s1_hold) begin
         s1_ff <= s1_in;
      end
      rsp_seen_ff <= rsp_seen_in;
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int RING = 8;
   localparam int FMAX = 128;
   localparam logic [fdttl_pkg::OP_W-1:0] OP_IGNORED = 2'd3;
   localparam int ITEM_TARGET = 1650;
   localparam int PHASES = 6;
   localparam int HIST_N = 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int MAX_SHOWN = 10;

   // dedupe predictor and store of expected seen flags
   class seen_scoreboard;
      logic [fdttl_pkg::BYTE_W-1:0] slot_data [RING][FMAX];
      logic [fdttl_pkg::POS_W-1:0]  slot_len [RING];
      logic [fdttl_pkg::TIME_W-1:0] slot_stamp [RING];
      int unsigned                  wr_slot;
      logic [fdttl_pkg::TIME_W-1:0] now_ms;
      int unsigned                  pos;
      logic [RING-1:0]              live;
      bit                           overflow;
      logic [fdttl_pkg::TTL_W-1:0]  ttl;
      bit                           seen_q[$];
      int                           errors;

      function new();
         int i, j;
         ttl = fdttl_pkg::TTL_RESET;
         wr_slot = 0;
         now_ms = '0;
         errors = 0;
         for (i = 0; i < RING; i++) begin
            slot_len[i] = '0;
            slot_stamp[i] = '0;
            for (j = 0; j < FMAX; j++) slot_data[i][j] = '0;
         end
         close_frame();
      endfunction

      function void close_frame();
         pos = 0;
         live = '1;
         overflow = 1'b0;
      endfunction

      function int pending();
         return seen_q.size();
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= MAX_SHOWN) $display("%0t: %s", $time, msg);
      endfunction

      // advance the ring by one accepted input transaction
      function void note_input(logic [fdttl_pkg::OP_W-1:0] op,
                               logic [fdttl_pkg::BYTE_W-1:0] b, logic last);
         int i;
         bit hit;
         logic [fdttl_pkg::TIME_W-1:0] age;
         if (op == fdttl_pkg::OP_TICK) begin
            now_ms = now_ms + 1;
            return;
         end
         if (op == OP_IGNORED) return;

         // compare or store one byte, drop bytes past the frame limit
         if (pos < FMAX) begin
            if (op == fdttl_pkg::OP_CHECK) begin
               for (i = 0; i < RING; i++) begin
                  if (pos >= slot_len[i] || slot_data[i][pos] != b) live[i] = 1'b0;
               end
            end else begin
               slot_data[wr_slot][pos] = b;
               slot_len[wr_slot] = '0;
            end
            pos++;
         end else begin
            overflow = 1'b1;
         end
         if (!last) return;

         // frame end: answer a check, or commit a remember
         if (op == fdttl_pkg::OP_CHECK) begin
            hit = 1'b0;
            if (!overflow) begin
               for (i = 0; i < RING; i++) begin
                  age = now_ms - slot_stamp[i];
                  if (live[i] && slot_len[i] == pos &&
                      age < fdttl_pkg::TIME_W'(ttl)) hit = 1'b1;
               end
            end
            seen_q.push_back(hit);
         end else if (overflow) begin
            slot_len[wr_slot] = '0;
         end else begin
            slot_len[wr_slot] = fdttl_pkg::POS_W'(pos);
            slot_stamp[wr_slot] = now_ms;
            wr_slot = (wr_slot + 1) % RING;
         end
         close_frame();
      endfunction

      // compare one result transaction with the oldest expectation
      function void check_result(logic seen);
         bit want;
         if (seen_q.size() == 0) begin
            flag($sformatf("result with none expected: seen=%b", seen));
            return;
         end
         want = seen_q.pop_front();
         if (seen !== want) flag($sformatf("seen mismatch: expected %b actual %b", want, seen));
      endfunction

      function void flag_leftovers();
         if (seen_q.size() != 0)
            flag($sformatf("%0d expected results never arrived", seen_q.size()));
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic [fdttl_pkg::OP_W-1:0] req_opcode = fdttl_pkg::OP_TICK;
   logic [fdttl_pkg::BYTE_W-1:0] req_data_byte = '0;
   logic req_last = 1'b0;
   logic rsp_stall = 1'b0;
   logic csr_valid = 1'b0;
   logic [fdttl_pkg::TTL_W-1:0] csr_ttl_ms = '0;
   wire req_stall, rsp_valid, rsp_seen, csr_ready;

   seen_scoreboard sb;
   bit quiet = 1'b0;
   int idle_odds = 6;
   int items_sent = 0;
   logic [fdttl_pkg::BYTE_W-1:0] frame_buf [256];
   logic [fdttl_pkg::BYTE_W-1:0] hist_data [HIST_N][FMAX];
   int hist_len [HIST_N];
   int hist_count = 0;

   frame_dedupe_ttl_cache dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_data_byte(req_data_byte),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_seen(rsp_seen),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_ttl_ms(csr_ttl_ms)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // monitor: ttl writes, result and input transactions
   always @(posedge clock) begin
      if (!reset && sb != null) begin
         if (csr_valid && csr_ready) sb.ttl = csr_ttl_ms;
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_seen);
         if (req_valid && !req_stall) sb.note_input(req_opcode, req_data_byte, req_last);
      end
   end

   // result side stall bursts
   initial begin : rsp_stall_gen
      int n;
      forever begin
         if (!quiet && idle_odds != 0 && $urandom_range(0, idle_odds * 2) == 0) begin
            n = $urandom_range(1, 14);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
      end
   end

   // no-progress watchdog
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle = 0;
         else
            idle++;
      end
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   // one input transaction, with an optional idle burst ahead of it
   task automatic send_item(input logic [fdttl_pkg::OP_W-1:0] op,
                            input logic [fdttl_pkg::BYTE_W-1:0] b,
                            input logic last);
      int gap;
      if (!quiet && idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_data_byte <= b;
      req_last <= last;
      do @(posedge clock); while (req_stall);
      if (op != OP_IGNORED) items_sent++;
   endtask

   // send frame_buf as one frame, keep clean remember frames for later checks
   task automatic send_frame(input logic [fdttl_pkg::OP_W-1:0] op, input int len);
      int k;
      for (k = 0; k < len; k++) send_item(op, frame_buf[k], k == len - 1);
      if (op == fdttl_pkg::OP_REMEMBER && len <= FMAX) begin
         for (k = 0; k < len; k++) hist_data[hist_count % HIST_N][k] = frame_buf[k];
         hist_len[hist_count % HIST_N] = len;
         hist_count++;
      end
   endtask

   task automatic ticks(input int n);
      repeat (n)
         send_item(fdttl_pkg::OP_TICK, fdttl_pkg::BYTE_W'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
   endtask

   function automatic void fill_random(input int len);
      int k;
      for (k = 0; k < len; k++) begin
         case ($urandom_range(0, 5))
            0: frame_buf[k] = 8'h00;
            1: frame_buf[k] = 8'hFF;
            2: frame_buf[k] = 8'h5A;
            default: frame_buf[k] = fdttl_pkg::BYTE_W'($urandom_range(0, 255));
         endcase
      end
   endfunction

   // copy a recent remembered frame into frame_buf, returns its length
   function automatic int recall();
      int back, idx, avail, k;
      avail = (hist_count < HIST_N) ? hist_count : HIST_N;
      back = $urandom_range(0, avail - 1);
      if (back > 9 && $urandom_range(0, 1) == 0) back = $urandom_range(0, 3);
      idx = (hist_count - 1 - back) % HIST_N;
      for (k = 0; k < hist_len[idx]; k++) frame_buf[k] = hist_data[idx][k];
      return hist_len[idx];
   endfunction

   function automatic int short_len();
      if ($urandom_range(0, 7) == 0) return $urandom_range(9, 24);
      return $urandom_range(1, 6);
   endfunction

   // wait until every expected result is back and the block is quiet
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_ttl(input logic [fdttl_pkg::TTL_W-1:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_ttl_ms <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic directed();
      // empty ring never matches
      frame_buf[0] = 8'h00;
      send_frame(fdttl_pkg::OP_CHECK, 1);
      // byte extremes, exact match, prefix and one-byte difference
      frame_buf[1] = 8'hFF;
      send_frame(fdttl_pkg::OP_REMEMBER, 2);
      send_frame(fdttl_pkg::OP_CHECK, 2);
      send_frame(fdttl_pkg::OP_CHECK, 1);
      send_item(OP_IGNORED, 8'hFF, 1'b1);
      send_item(OP_IGNORED, 8'h00, 1'b0);
      frame_buf[1] = 8'hFE;
      send_frame(fdttl_pkg::OP_CHECK, 2);
      // tick with its byte and last fields set, still young
      send_item(fdttl_pkg::OP_TICK, 8'hFF, 1'b1);
      frame_buf[1] = 8'hFF;
      send_frame(fdttl_pkg::OP_CHECK, 2);
      // mixed frame: remember byte first, checked last byte
      send_item(fdttl_pkg::OP_REMEMBER, 8'h00, 1'b0);
      send_item(fdttl_pkg::OP_CHECK, 8'hFF, 1'b1);
      // hold off until every result is back
      drain();
      // zero ttl matches nothing
      write_ttl('0);
      send_frame(fdttl_pkg::OP_CHECK, 2);
      // ttl of one: only age zero counts
      write_ttl(16'd1);
      send_frame(fdttl_pkg::OP_CHECK, 2);
      frame_buf[0] = 8'h5A;
      send_frame(fdttl_pkg::OP_REMEMBER, 1);
      send_frame(fdttl_pkg::OP_CHECK, 1);
      send_item(fdttl_pkg::OP_TICK, 8'h00, 1'b0);
      send_frame(fdttl_pkg::OP_CHECK, 1);
   endtask

   // full-size and over-long frames
   task automatic long_frames();
      fill_random(FMAX);
      send_frame(fdttl_pkg::OP_REMEMBER, FMAX);
      send_frame(fdttl_pkg::OP_CHECK, FMAX);
      frame_buf[FMAX] = fdttl_pkg::BYTE_W'($urandom_range(0, 255));
      send_frame(fdttl_pkg::OP_REMEMBER, FMAX + 1);
      send_frame(fdttl_pkg::OP_CHECK, FMAX + 1);
   endtask

   task automatic random_step();
      int r, len, k, m;
      r = $urandom_range(0, 199);
      if (r < 48) begin
         // remember a fresh frame
         len = short_len();
         fill_random(len);
         send_frame(fdttl_pkg::OP_REMEMBER, len);
      end else if (r < 118 && hist_count != 0) begin
         // check a recent frame, exact or slightly altered
         len = recall();
         m = $urandom_range(0, 9);
         if (m == 6 || m == 7) begin
            k = $urandom_range(0, len - 1);
            frame_buf[k] = frame_buf[k] ^ fdttl_pkg::BYTE_W'(1 << $urandom_range(0, 7));
         end else if (m == 8 && len > 1) begin
            len--;
         end else if (m == 9) begin
            frame_buf[len] = fdttl_pkg::BYTE_W'($urandom_range(0, 255));
            len++;
         end
         send_frame(fdttl_pkg::OP_CHECK, len);
      end else if (r < 134) begin
         len = short_len();
         fill_random(len);
         send_frame(fdttl_pkg::OP_CHECK, len);
      end else if (r < 166) begin
         ticks($urandom_range(1, 4));
      end else if (r < 178) begin
         // mixed opcodes in one frame, last byte checked
         if (hist_count != 0 && $urandom_range(0, 1) == 0) begin
            len = recall();
         end else begin
            len = $urandom_range(2, 6);
            fill_random(len);
         end
         for (k = 0; k < len - 1; k++)
            send_item($urandom_range(0, 1) ? fdttl_pkg::OP_CHECK : fdttl_pkg::OP_REMEMBER,
                      frame_buf[k], 1'b0);
         send_item(fdttl_pkg::OP_CHECK, frame_buf[len - 1], 1'b1);
      end else if (r < 198) begin
         repeat ($urandom_range(1, 3))
            send_item(OP_IGNORED, fdttl_pkg::BYTE_W'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
      end else begin
         len = $urandom_range(100, FMAX);
         fill_random(len);
         send_frame(fdttl_pkg::OP_REMEMBER, len);
      end
   endtask

   initial begin : main
      int ph;
      logic [fdttl_pkg::TTL_W-1:0] ttl_val;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      directed();

      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: ttl_val = 16'hFFFF;
            1: ttl_val = 16'd1;
            2: ttl_val = fdttl_pkg::TTL_W'($urandom_range(2, 12));
            3: ttl_val = '0;
            4: ttl_val = fdttl_pkg::TTL_W'($urandom_range(13, 400));
            default: ttl_val = fdttl_pkg::TTL_W'($urandom_range(2, 20));
         endcase
         write_ttl(ttl_val);
         case (ph)
            0: idle_odds = 8;
            1: idle_odds = 0;
            2: idle_odds = 3;
            3: idle_odds = 10;
            default: idle_odds = 5;
         endcase
         quiet = (ph == PHASES - 1);
         if (ph == 0) long_frames();
         while (items_sent < (ph + 1) * ITEM_TARGET / PHASES) random_step();
      end

      drain();
      repeat (4) @(posedge clock);
      sb.flag_leftovers();
      if (sb.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
